[design/minmax_frame_normalizer_macros.svh]
// Assertion macros for the min/max frame normalizer.
`ifndef MINMAX_FRAME_NORMALIZER_MACROS_SVH
`define MINMAX_FRAME_NORMALIZER_MACROS_SVH

`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define MMFN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that cons holds in the cycle after ante.
`define MMFN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MMFN_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MMFN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[design/mmfn_pkg.sv]
// Shared constants, codes and types of the min/max frame normalizer.
package mmfn_pkg;

    localparam int MAX_PIXELS  = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_BITS   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CNT_BITS    = $clog2(MAX_PIXELS + 1);
    localparam int LEVEL_BITS  = 8;
    localparam int NUM_BITS    = SAMPLE_BITS + LEVEL_BITS;
    localparam int STEP_BITS   = $clog2(LEVEL_BITS + 1);

    localparam logic [CNT_BITS-1:0]    CNT_MAX   = CNT_BITS'(MAX_PIXELS);
    localparam logic [SAMPLE_BITS-1:0] ONE_Q12   = SAMPLE_BITS'(4096);
    localparam logic [LEVEL_BITS-1:0]  LEVEL_TOP = {LEVEL_BITS{1'b1}};

    // Input operation codes (carried in tuser)
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    // Output channel codes
    localparam logic [1:0] CH_R = 2'd0;
    localparam logic [1:0] CH_G = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;

    // Configuration register indexes
    localparam logic REG_NORMALIZE_ON = 1'b0;
    localparam logic REG_RGB_MODE     = 1'b1;

    // Divider status toward the control logic
    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [LEVEL_BITS-1:0] quot;
    } mmfn_div_st_t;

endpackage

[design/minmax_frame_normalizer.sv]
// Top level of the min/max frame normalizer: sample store, frame tracking and output.
//
// Load words (tuser 0) write one sample into the 4096-entry sample RAM and update the
// frame minimum and maximum; a load gives no result, and the block stays ready for the
// next word. Emit words (tuser 1) read the next stored pixel and scale it to 0..255 as
// floor((v - min) * 255 / range); with normalization off min is 0 and range is 1.0.
// An emit gives one result word in gray mode and three in RGB mode; it passes through
// the RAM read and the 9-step restoring divider. When the level saturates at 255 the
// divider stops after its first step. An emit past the end of the frame gives one
// error word. Output stalls lengthen an emit. Only one word is in work at a time,
// but the next word is accepted while the last result still waits in the output register.
// The sample RAM needs no clearing after reset. A configuration write takes effect at
// any cycle, so write configuration only while the block is idle.
`include "minmax_frame_normalizer_macros.svh"

module minmax_frame_normalizer
    import mmfn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic                   cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample
    input  logic                   s_tuser,   // [0] op
    input  logic                   s_tlast,   // frame_end
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [LEVEL_BITS-1:0]  m_tdata,   // [7:0] level
    output logic [3:0]             m_tuser,   // [1:0] channel, [2] pixel_last, [3] empty_error
    output logic                   m_tlast    // run_last
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_SEND  = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0]  frame_min_reg, frame_min_next;
    logic signed [SAMPLE_BITS-1:0]  frame_max_reg, frame_max_next;
    logic [CNT_BITS-1:0]            stored_count_reg, stored_count_next;
    logic [CNT_BITS-1:0]            read_ptr_reg, read_ptr_next;
    logic                           frame_closed_reg, frame_closed_next;
    logic                           normalize_on_reg, rgb_mode_reg;
    logic [LEVEL_BITS-1:0]          level_reg, level_next;
    logic                           pix_last_reg, pix_last_next;
    logic                           err_reg, err_next;
    logic [1:0]                     chan_reg, chan_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [LEVEL_BITS-1:0]          m_tdata_reg, m_tdata_next;
    logic [3:0]                     m_tuser_reg, m_tuser_next;
    logic                           m_tlast_reg, m_tlast_next;

    // load path temporaries
    logic signed [SAMPLE_BITS-1:0]  sample;
    logic [CNT_BITS-1:0]            base_count;
    logic signed [SAMPLE_BITS-1:0]  base_min, base_max;
    logic                           run_last;
    logic                           out_free;

    // RAM and divider hookup
    logic                           ram_we, ram_re;
    logic [ADDR_BITS-1:0]           ram_waddr;
    logic [SAMPLE_BITS-1:0]         ram_rdata;
    logic                           div_start;
    logic [NUM_BITS-1:0]            div_num;
    logic [SAMPLE_BITS-1:0]         div_den;
    mmfn_div_st_t                   div_st;

    // scaling operands
    logic signed [SAMPLE_BITS:0]    lo_ext;
    logic signed [SAMPLE_BITS:0]    span_ext;
    logic signed [SAMPLE_BITS:0]    diff;
    logic [SAMPLE_BITS-1:0]         diff_mag;

    assign sample   = signed'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    mmfn_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_PIXELS)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_tdata),
        .re   (ram_re),
        .raddr(read_ptr_reg[ADDR_BITS-1:0]),
        .rdata(ram_rdata)
    );

    // Form numerator (diff * 255) and divisor from the fetched sample
    always_comb
    begin
        lo_ext   = normalize_on_reg ? {frame_min_reg[SAMPLE_BITS-1], frame_min_reg} : '0;
        span_ext = {frame_max_reg[SAMPLE_BITS-1], frame_max_reg}
                 - {frame_min_reg[SAMPLE_BITS-1], frame_min_reg};
        diff     = signed'({ram_rdata[SAMPLE_BITS-1], ram_rdata}) - lo_ext;
        diff_mag = diff[SAMPLE_BITS-1:0];
        if (diff[SAMPLE_BITS] || (diff == '0))
        begin
            div_num = '0;
        end
        else
        begin
            div_num = {diff_mag, {LEVEL_BITS{1'b0}}} - NUM_BITS'(diff_mag);
        end
        if (!normalize_on_reg || (span_ext == '0))
        begin
            div_den = ONE_Q12;
        end
        else
        begin
            div_den = span_ext[SAMPLE_BITS-1:0];
        end
    end

    mmfn_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .st   (div_st)
    );

    // Sequencer, frame tracking and output register
    always_comb
    begin
        state_next        = state_reg;
        frame_min_next    = frame_min_reg;
        frame_max_next    = frame_max_reg;
        stored_count_next = stored_count_reg;
        read_ptr_next     = read_ptr_reg;
        frame_closed_next = frame_closed_reg;
        level_next        = level_reg;
        pix_last_next     = pix_last_reg;
        err_next          = err_reg;
        chan_next         = chan_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        m_tlast_next      = m_tlast_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        div_start         = 1'b0;
        base_count        = frame_closed_reg ? '0 : stored_count_reg;
        base_min          = frame_closed_reg ? sample : frame_min_reg;
        base_max          = frame_closed_reg ? sample : frame_max_reg;
        ram_waddr         = base_count[ADDR_BITS-1:0];
        run_last          = err_reg || !rgb_mode_reg || (chan_reg == CH_B);

        // drop the output word once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OP_LOAD)
                    begin
                        if (frame_closed_reg)
                        begin
                            read_ptr_next = '0;
                        end
                        if (base_count < CNT_MAX)
                        begin
                            ram_we            = 1'b1;
                            stored_count_next = base_count + 1'b1;
                            frame_min_next    = (sample < base_min) ? sample : base_min;
                            frame_max_next    = (sample > base_max) ? sample : base_max;
                        end
                        else
                        begin
                            stored_count_next = base_count;
                            frame_min_next    = base_min;
                            frame_max_next    = base_max;
                        end
                        frame_closed_next = s_tlast;
                    end
                    else if (read_ptr_reg < stored_count_reg)
                    begin
                        ram_re        = 1'b1;
                        read_ptr_next = read_ptr_reg + 1'b1;
                        pix_last_next = ((read_ptr_reg + 1'b1) == stored_count_reg);
                        err_next      = 1'b0;
                        chan_next     = CH_R;
                        state_next    = ST_FETCH;
                    end
                    else
                    begin
                        level_next    = '0;
                        pix_last_next = 1'b0;
                        err_next      = 1'b1;
                        chan_next     = CH_R;
                        state_next    = ST_SEND;
                    end
                end
            end
            ST_FETCH:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_st.done)
                begin
                    level_next = div_st.quot;
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = level_reg;
                    m_tuser_next  = {err_reg, pix_last_reg, chan_reg};
                    m_tlast_next  = run_last;
                    if (run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        chan_next = chan_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_min_reg    <= '0;
            frame_max_reg    <= '0;
            stored_count_reg <= '0;
            read_ptr_reg     <= '0;
            frame_closed_reg <= 1'b1;
            normalize_on_reg <= 1'b1;
            rgb_mode_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            frame_min_reg    <= frame_min_next;
            frame_max_reg    <= frame_max_next;
            stored_count_reg <= stored_count_next;
            read_ptr_reg     <= read_ptr_next;
            frame_closed_reg <= frame_closed_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (cfg_we && (cfg_index == REG_NORMALIZE_ON))
            begin
                normalize_on_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_RGB_MODE))
            begin
                rgb_mode_reg <= cfg_data;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        level_reg    <= level_next;
        pix_last_reg <= pix_last_next;
        err_reg      <= err_next;
        chan_reg     <= chan_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `MMFN_ASSERT_NOW(a_idle_div_quiet, clk, rst_n, s_tready, !div_st.busy)
    `MMFN_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, stored_count_reg <= CNT_MAX)
    `MMFN_ASSERT_NOW(a_ptr_le_count, clk, rst_n, 1'b1, read_ptr_reg <= stored_count_reg)
    `MMFN_ASSERT_NOW(a_min_le_max, clk, rst_n, 1'b1, frame_min_reg <= frame_max_reg)
    `MMFN_ASSERT_NEXT(a_fetch_starts_div, clk, rst_n, state_reg == ST_FETCH, div_st.busy)

endmodule

[design/mmfn_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mmfn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/mmfn_divider.sv]
// Restoring divider giving an 8-bit quotient that saturates at the top level.
module mmfn_divider
    import mmfn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUM_BITS-1:0]    num,
    input  logic [SAMPLE_BITS-1:0] den,
    output mmfn_div_st_t           st
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic                  sat_reg;
    logic [NUM_BITS-1:0]   rem_reg;
    logic [NUM_BITS-1:0]   dsh_reg;
    logic [LEVEL_BITS-1:0] quot_reg;
    logic                  fits;
    logic                  top_step;

    // Trial compare against the shifted divisor
    assign fits     = (rem_reg >= dsh_reg);
    assign top_step = (step_reg == STEP_BITS'(LEVEL_BITS));

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_BITS'(LEVEL_BITS);
        end
        else if (busy_reg)
        begin
            if ((top_step && fits) || (step_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: first step only detects a quotient past the top level
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            dsh_reg  <= {den, {LEVEL_BITS{1'b0}}};
            sat_reg  <= 1'b0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (top_step)
            begin
                sat_reg <= fits;
            end
            else
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quot_reg <= {quot_reg[LEVEL_BITS-2:0], fits};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign st.busy = busy_reg;
    assign st.done = done_reg;
    assign st.quot = sat_reg ? LEVEL_TOP : quot_reg;

endmodule
